// ===== sv/assert_macros.svh =====
// Assertion shorthands; the enclosing module provides clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every edge outside reset.
`define HRT_ASSERT(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Trigger at one edge implies consequence at the next.
`define HRT_ASSERT_NEXT(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/hrt_pkg.sv =====
package hrt_pkg;

   localparam int MaxHeadersDefault = 16;
   localparam int MaxResults        = 4;
   localparam int ResCntW           = 3;
   localparam int ResIdxW           = 2;
   localparam int HdrNumW           = 5;

   localparam logic [7:0] CharColon = 8'h3A;
   localparam logic [7:0] CharSp    = 8'h20;
   localparam logic [7:0] CharTab   = 8'h09;
   localparam logic [7:0] CharCr    = 8'h0D;
   localparam logic [7:0] CharLf    = 8'h0A;

   typedef enum logic [2:0] {
      KIND_METHOD,
      KIND_URI,
      KIND_VERSION,
      KIND_NAME,
      KIND_VALUE,
      KIND_LINE_END,
      KIND_STATUS
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_UNEXPECTED_END,
      STATUS_TOO_MANY
   } status_type;

   typedef enum logic [2:0] {
      PH_REQ,
      PH_LSTART,
      PH_LSTART_CR,
      PH_NAME,
      PH_VALUE,
      PH_VAL_CR,
      PH_VAL_LF,
      PH_DONE
   } phase_type;

   typedef struct packed {
      kind_type             kind;
      logic [7:0]           out_byte;
      logic [HdrNumW-1:0]   header_number;
      status_type           status;
   } result_type;

   // All results caused by one input byte, slot 0 first.
   typedef struct packed {
      result_type [MaxResults-1:0] res;
      logic [ResCntW-1:0]          count;
   } group_type;

endpackage

// ===== sv/hrt_classify.sv =====
`include "assert_macros.svh"

module hrt_classify #(
   parameter int MAX_HEADERS = hrt_pkg::MaxHeadersDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_fire,
   input  logic [7:0]          step_byte,
   input  logic                step_final,
   output hrt_pkg::group_type  step_group
);

   localparam int CntW = hrt_pkg::ResCntW;
   localparam int IdxW = hrt_pkg::ResIdxW;
   localparam int HnW  = hrt_pkg::HdrNumW;
   localparam int HcW  = $clog2(MAX_HEADERS + 1);
   localparam logic [HcW-1:0] HcMax = HcW'(MAX_HEADERS);

   typedef struct packed {
      hrt_pkg::phase_type  ph;
      logic [1:0]          lf;
      logic [HcW-1:0]      hc;
      logic                vs;
      logic [1:0]          hn;
      hrt_pkg::group_type  g;
   } walk_type;

   hrt_pkg::phase_type  phase_ff;
   logic [1:0]          line_field_ff;
   logic [HcW-1:0]      header_count_ff;
   logic                value_started_ff;
   logic [1:0]          held_count_ff;
   walk_type            w;

   function automatic logic is_blank(logic [7:0] b);
      return (b == hrt_pkg::CharSp) || (b == hrt_pkg::CharTab);
   endfunction

   function automatic walk_type f_emit(walk_type s, hrt_pkg::kind_type k, logic [7:0] b,
                                       hrt_pkg::status_type st);
      walk_type r;
      r = s;
      if (r.g.count < CntW'(hrt_pkg::MaxResults)) begin
         r.g.res[r.g.count[IdxW-1:0]] = '{kind: k, out_byte: b,
                                          header_number: HnW'(r.hc), status: st};
         r.g.count = r.g.count + CntW'(1);
      end
      return r;
   endfunction

   function automatic walk_type f_finish(walk_type s, hrt_pkg::status_type st);
      walk_type r;
      r = f_emit(s, hrt_pkg::KIND_STATUS, 8'h00, st);
      r.hn = '0;
      r.ph = hrt_pkg::PH_DONE;
      return r;
   endfunction

   function automatic walk_type f_in_name(walk_type s, logic [7:0] b);
      walk_type r;
      r = s;
      if (b == hrt_pkg::CharColon) begin
         r.ph = hrt_pkg::PH_VALUE;
         r.vs = 1'b0;
      end else if (is_blank(b)) begin
         r = s;
      end else if (b == hrt_pkg::CharCr || b == hrt_pkg::CharLf) begin
         r = f_finish(s, hrt_pkg::STATUS_UNEXPECTED_END);
      end else begin
         r = f_emit(s, hrt_pkg::KIND_NAME, b, hrt_pkg::STATUS_OK);
      end
      return r;
   endfunction

   function automatic walk_type f_in_value(walk_type s, logic [7:0] b);
      walk_type r;
      r = s;
      if (b == hrt_pkg::CharCr) begin
         r.hn = 2'd1;
         r.ph = hrt_pkg::PH_VAL_CR;
      end else if (b == hrt_pkg::CharLf) begin
         r.hn = 2'd1;
         r.ph = hrt_pkg::PH_VAL_LF;
      end else if (!r.vs && is_blank(b)) begin
         r = s;
      end else begin
         r.vs = 1'b1;
         r = f_emit(r, hrt_pkg::KIND_VALUE, b, hrt_pkg::STATUS_OK);
      end
      return r;
   endfunction

   function automatic walk_type f_line_start(walk_type s, logic [7:0] b);
      walk_type r;
      r = s;
      if (b == hrt_pkg::CharLf) begin
         r = f_finish(s, hrt_pkg::STATUS_OK);
      end else if (b == hrt_pkg::CharCr) begin
         r.hn = 2'd1;
         r.ph = hrt_pkg::PH_LSTART_CR;
      end else if (s.hc >= HcMax) begin
         r = f_finish(s, hrt_pkg::STATUS_TOO_MANY);
      end else begin
         r.ph = hrt_pkg::PH_NAME;
         r = f_in_name(r, b);
      end
      return r;
   endfunction

   always_comb begin
      w    = '0;
      w.ph = phase_ff;
      w.lf = line_field_ff;
      w.hc = header_count_ff;
      w.vs = value_started_ff;
      w.hn = held_count_ff;
      unique case (phase_ff)
         hrt_pkg::PH_REQ: begin
            if (step_final) begin
               w = f_finish(w, hrt_pkg::STATUS_UNEXPECTED_END);
            end else if (step_byte == hrt_pkg::CharSp && w.lf < 2'd2) begin
               w.lf = w.lf + 2'd1;
            end else if (step_byte == hrt_pkg::CharCr) begin
               w.lf = line_field_ff;
            end else if (step_byte == hrt_pkg::CharLf) begin
               if (w.lf < 2'd2) w = f_finish(w, hrt_pkg::STATUS_UNEXPECTED_END);
               else w.ph = hrt_pkg::PH_LSTART;
            end else begin
               w = f_emit(w, hrt_pkg::kind_type'({1'b0, w.lf}), step_byte,
                          hrt_pkg::STATUS_OK);
            end
         end
         hrt_pkg::PH_LSTART: begin
            w = f_line_start(w, step_byte);
         end
         hrt_pkg::PH_LSTART_CR: begin
            w.hn = '0;
            if (step_byte == hrt_pkg::CharLf) w = f_finish(w, hrt_pkg::STATUS_OK);
            else if (w.hc >= HcMax) w = f_finish(w, hrt_pkg::STATUS_TOO_MANY);
            else w = f_finish(w, hrt_pkg::STATUS_UNEXPECTED_END);
         end
         hrt_pkg::PH_NAME: begin
            w = f_in_name(w, step_byte);
         end
         hrt_pkg::PH_VALUE: begin
            w = f_in_value(w, step_byte);
         end
         hrt_pkg::PH_VAL_CR: begin
            if (step_byte == hrt_pkg::CharLf) begin
               w.hn = 2'd2;
               w.ph = hrt_pkg::PH_VAL_LF;
            end else begin
               w.hn = '0;
               w.ph = hrt_pkg::PH_VALUE;
               w.vs = 1'b1;
               w = f_emit(w, hrt_pkg::KIND_VALUE, hrt_pkg::CharCr, hrt_pkg::STATUS_OK);
               w = f_in_value(w, step_byte);
            end
         end
         hrt_pkg::PH_VAL_LF: begin
            w.hn = '0;
            if (is_blank(step_byte)) begin
               // folded line: one value space per line-break byte plus the blank
               w = f_emit(w, hrt_pkg::KIND_VALUE, hrt_pkg::CharSp, hrt_pkg::STATUS_OK);
               if (held_count_ff >= 2'd1)
                  w = f_emit(w, hrt_pkg::KIND_VALUE, hrt_pkg::CharSp, hrt_pkg::STATUS_OK);
               if (held_count_ff >= 2'd2)
                  w = f_emit(w, hrt_pkg::KIND_VALUE, hrt_pkg::CharSp, hrt_pkg::STATUS_OK);
               w.vs = 1'b1;
               w.ph = hrt_pkg::PH_VALUE;
            end else begin
               w = f_emit(w, hrt_pkg::KIND_LINE_END, 8'h00, hrt_pkg::STATUS_OK);
               w.hc = w.hc + HcW'(1);
               w.ph = hrt_pkg::PH_LSTART;
               w = f_line_start(w, step_byte);
            end
         end
         hrt_pkg::PH_DONE: begin
            w.ph = hrt_pkg::PH_DONE;
         end
      endcase
      if (step_final && w.ph != hrt_pkg::PH_DONE) begin
         w = f_finish(w, hrt_pkg::STATUS_UNEXPECTED_END);
      end
   end

   assign step_group = w.g;

   always_ff @(posedge clock) begin
      if (reset || (step_fire && step_final)) begin
         phase_ff         <= hrt_pkg::PH_REQ;
         line_field_ff    <= '0;
         header_count_ff  <= '0;
         value_started_ff <= 1'b0;
         held_count_ff    <= '0;
      end else if (step_fire) begin
         phase_ff         <= w.ph;
         line_field_ff    <= w.lf;
         header_count_ff  <= w.hc;
         value_started_ff <= w.vs;
         held_count_ff    <= w.hn;
      end
   end

   `HRT_ASSERT(a_hc_bound, header_count_ff <= HcMax, "header count above limit")
   `HRT_ASSERT(a_grp_bound, step_group.count <= CntW'(hrt_pkg::MaxResults), "too many results")
   `HRT_ASSERT_NEXT(a_final_rst, step_fire && step_final, phase_ff == hrt_pkg::PH_REQ, "no return to request line after final byte")

endmodule

// ===== sv/hrt_serialize.sv =====
`include "assert_macros.svh"

module hrt_serialize (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load_valid,
   input  hrt_pkg::group_type            load_group,
   output logic                          load_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [2:0]                    rsp_kind,
   output logic [7:0]                    rsp_out_byte,
   output logic [hrt_pkg::HdrNumW-1:0]   rsp_header_number,
   output logic [1:0]                    rsp_status,
   output logic                          rsp_last_of_run
);

   localparam int CntW = hrt_pkg::ResCntW;
   localparam int IdxW = hrt_pkg::ResIdxW;

   hrt_pkg::result_type [hrt_pkg::MaxResults-1:0] res_ff;
   logic [CntW-1:0]     cnt_ff;
   logic [IdxW-1:0]     idx_ff;
   logic                valid_ff;
   logic                is_last;
   logic                take;
   logic                load;
   hrt_pkg::result_type cur;

   assign cur        = res_ff[idx_ff];
   assign is_last    = (CntW'(idx_ff) + CntW'(1)) == cnt_ff;
   assign take       = valid_ff && !rsp_stall;
   assign load_ready = !valid_ff || (take && is_last);
   assign load       = load_valid && (load_group.count != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (take && is_last) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= load_group.res;
         cnt_ff <= load_group.count;
         idx_ff <= '0;
      end else if (take && !is_last) begin
         idx_ff <= idx_ff + IdxW'(1);
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_kind          = cur.kind;
   assign rsp_out_byte      = cur.out_byte;
   assign rsp_header_number = cur.header_number;
   assign rsp_status        = cur.status;
   assign rsp_last_of_run   = is_last;

   `HRT_ASSERT(a_idx_in_range, !valid_ff || (CntW'(idx_ff) < cnt_ff), "result index past count")
   `HRT_ASSERT(a_status_last, !(valid_ff && cur.kind == hrt_pkg::KIND_STATUS) || is_last, "status word not last of run")

endmodule

// ===== sv/http_request_header_tokenizer.sv =====
// Channel   Dir  Handshake             Payload
// req_      in   req_valid/req_stall   data_byte[7:0], is_final
// rsp_      out  rsp_valid/rsp_stall   kind[2:0], out_byte[7:0], header_number[4:0],
//                                      status[1:0], last_of_run
//
// A byte is registered, classified combinationally and its words (zero to four) load the
// result stage, from which the first word goes out on rsp_. Bytes giving at most one word
// flow at one per cycle while rsp_stall is low; a byte giving more words keeps the result
// stage, and the next byte in the input register, busy until its last word is taken.
// Synchronous reset, and any byte with is_final once its words are queued, return to
// the request method; rsp_stall holds the word, req_stall marks a byte left waiting.
module http_request_header_tokenizer #(
   parameter int MAX_HEADERS = hrt_pkg::MaxHeadersDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_data_byte,
   input  logic                          req_is_final,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [2:0]                    rsp_kind,
   output logic [7:0]                    rsp_out_byte,
   output logic [hrt_pkg::HdrNumW-1:0]   rsp_header_number,
   output logic [1:0]                    rsp_status,
   output logic                          rsp_last_of_run
);

   // input register
   logic               in_valid_ff;
   logic [7:0]         in_byte_ff;
   logic               in_final_ff;

   logic               grp_ready;
   logic               step_fire;
   hrt_pkg::group_type step_group;

   // The byte moves on when the result stage is empty or emptying this cycle.
   assign step_fire = in_valid_ff && grp_ready;
   assign req_stall = in_valid_ff && !grp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_valid_ff <= 1'b1;
      end else if (step_fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff  <= req_data_byte;
         in_final_ff <= req_is_final;
      end
   end

   // Parser state and per-byte classification.
   hrt_classify #(
      .MAX_HEADERS (MAX_HEADERS)
   ) u_classify (
      .clock      (clock),
      .reset      (reset),
      .step_fire  (step_fire),
      .step_byte  (in_byte_ff),
      .step_final (in_final_ff),
      .step_group (step_group)
   );

   // Result stage: holds one byte's words and hands them out in order.
   hrt_serialize u_serialize (
      .clock             (clock),
      .reset             (reset),
      .load_valid        (step_fire),
      .load_group        (step_group),
      .load_ready        (grp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_header_number (rsp_header_number),
      .rsp_status        (rsp_status),
      .rsp_last_of_run   (rsp_last_of_run)
   );

endmodule
